// File: rtl/core/sld_pkg.sv
`timescale 1ns / 1ps

package sld_pkg;

    // field widths of the frame words
    localparam int unsigned BYTE_W = 8;
    localparam int unsigned LEN_W  = 9;

    // configuration register indexes
    localparam int unsigned REG_SYNC_VALUE = 0;

    // reset value of the sync byte register
    localparam logic [BYTE_W-1:0] SYNC_RESET = 8'hAA;

    // frame ids with their own payload rules
    localparam logic [BYTE_W-1:0] ID_DOUBLE_IV = 8'd1;
    localparam logic [BYTE_W-1:0] ID_PLAIN     = 8'd2;

    // parser phase, one-hot
    typedef enum logic [3:0] {
        PH_HUNT = 4'b0001,
        PH_LEN  = 4'b0010,
        PH_ID   = 4'b0100,
        PH_DATA = 4'b1000
    } t_phase;

    // one result word from the parser to the output register
    typedef struct packed {
        logic              emit;
        logic [BYTE_W-1:0] payload_byte;
        logic [BYTE_W-1:0] frame_id;
        logic [BYTE_W-1:0] frame_length;
        logic [LEN_W-1:0]  padded_length;
        logic [LEN_W-1:0]  byte_index;
        logic              last_byte;
    } t_result;

endpackage

// File: rtl/core/sld_parser.sv
`timescale 1ns / 1ps

module sld_parser #(
    parameter int HEADER_LEN = 2,
    parameter int IV_LEN     = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_step,
    input  logic [sld_pkg::BYTE_W-1:0] i_byte,
    input  logic [sld_pkg::BYTE_W-1:0] i_sync_value,
    output sld_pkg::t_result           o_res
);
    import sld_pkg::*;

    localparam int SYNC_W = $clog2(HEADER_LEN + 1);
    localparam logic [SYNC_W-1:0] SYNC_TARGET = SYNC_W'(HEADER_LEN);
    localparam logic [LEN_W-1:0]  EXTRA_DOUBLE = LEN_W'(2 * IV_LEN + HEADER_LEN);
    localparam logic [LEN_W-1:0]  EXTRA_PLAIN  = LEN_W'(2 + HEADER_LEN);
    localparam logic [LEN_W-1:0]  EXTRA_OTHER  = LEN_W'(IV_LEN + HEADER_LEN);

    t_phase             r_phase, n_phase;
    logic [SYNC_W-1:0]  r_sync_count, n_sync_count;
    logic [BYTE_W-1:0]  r_length, n_length;
    logic [BYTE_W-1:0]  r_id, n_id;
    logic [LEN_W-1:0]   r_padded, n_padded;
    logic [LEN_W-1:0]   r_total, n_total;
    logic [LEN_W-1:0]   r_pos, n_pos;

    logic [LEN_W-1:0]   len_plus;
    logic [SYNC_W-1:0]  sync_inc;
    logic [LEN_W:0]     pos_inc;
    logic               is_last;

    // round L+5 up to a multiple of sixteen
    assign len_plus = LEN_W'(i_byte) + LEN_W'(20);
    assign sync_inc = r_sync_count + SYNC_W'(1);
    assign pos_inc  = (LEN_W+1)'(r_pos) + (LEN_W+1)'(1);
    assign is_last  = pos_inc >= (LEN_W+1)'(r_total);

    // next state for one word
    always_comb begin
        n_phase      = r_phase;
        n_sync_count = r_sync_count;
        n_length     = r_length;
        n_id         = r_id;
        n_padded     = r_padded;
        n_total      = r_total;
        n_pos        = r_pos;
        case (r_phase)
            PH_HUNT: begin
                if (i_byte == i_sync_value) begin
                    if (sync_inc == SYNC_TARGET) begin
                        n_sync_count = '0;
                        n_phase      = PH_LEN;
                    end else begin
                        n_sync_count = sync_inc;
                    end
                end
            end
            PH_LEN: begin
                n_length = i_byte;
                n_padded = {len_plus[LEN_W-1:4], 4'b0000};
                n_phase  = PH_ID;
            end
            PH_ID: begin
                n_id  = i_byte;
                n_pos = '0;
                if (i_byte == ID_DOUBLE_IV) begin
                    n_total = r_padded + EXTRA_DOUBLE;
                end else if (i_byte == ID_PLAIN) begin
                    n_total = LEN_W'(r_length) + EXTRA_PLAIN;
                end else begin
                    n_total = r_padded + EXTRA_OTHER;
                end
                n_phase = PH_DATA;
            end
            PH_DATA: begin
                if (is_last) begin
                    n_phase = PH_HUNT;
                    n_pos   = '0;
                end else begin
                    n_pos = pos_inc[LEN_W-1:0];
                end
            end
            default: begin
                n_phase = PH_HUNT;
            end
        endcase
    end

    // result word for a payload byte
    always_comb begin
        o_res.emit          = (r_phase == PH_DATA);
        o_res.payload_byte  = i_byte;
        o_res.frame_id      = r_id;
        o_res.frame_length  = r_length;
        o_res.padded_length = r_padded;
        o_res.byte_index    = r_pos;
        o_res.last_byte     = is_last;
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_HUNT;
            r_sync_count <= '0;
            r_length     <= '0;
            r_id         <= '0;
            r_padded     <= '0;
            r_total      <= '0;
            r_pos        <= '0;
        end else if (i_step) begin
            r_phase      <= n_phase;
            r_sync_count <= n_sync_count;
            r_length     <= n_length;
            r_id         <= n_id;
            r_padded     <= n_padded;
            r_total      <= n_total;
            r_pos        <= n_pos;
        end
    end

endmodule

// File: rtl/core/sync_length_id_frame_deframer.sv
`timescale 1ns / 1ps

// Frame deframer for a serial byte stream: hunts for HEADER_LEN bytes equal
// to the sync register (other bytes are skipped without clearing the count),
// then takes a length byte and an id byte, and hands out every payload byte
// with the frame's id, length, padded length, index and a last flag. Header,
// length and id bytes give no output word. One byte is accepted every clock
// cycle unless the input side stalls; a byte passes an input register and the
// header/payload parser, and a payload byte goes on into the output register.
// The input stalls only when the output register is full and not being taken.
module sync_length_id_frame_deframer #(
    parameter int HEADER_LEN = 2,
    parameter int IV_LEN     = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // byte input
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [sld_pkg::BYTE_W-1:0] i_rx_byte,
    // payload output
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [sld_pkg::BYTE_W-1:0] o_payload_byte,
    output logic [sld_pkg::BYTE_W-1:0] o_frame_id,
    output logic [sld_pkg::BYTE_W-1:0] o_frame_length,
    output logic [sld_pkg::LEN_W-1:0]  o_padded_length,
    output logic [sld_pkg::LEN_W-1:0]  o_byte_index,
    output logic                       o_last_byte,
    // register port
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [2:0]                 paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);
    import sld_pkg::*;

    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_out_valid;
    t_result           r_out;
    logic [BYTE_W-1:0] r_sync_value;
    logic              advance;
    logic              reg_hit;
    t_result           res;

    // register file: one sync byte register
    assign pready  = 1'b1;
    assign reg_hit = (paddr[2] == 1'(REG_SYNC_VALUE));
    assign prdata  = reg_hit ? {{(32-BYTE_W){1'b0}}, r_sync_value} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_value <= SYNC_RESET;
        end else if (psel && penable && pwrite && reg_hit) begin
            r_sync_value <= pwdata[BYTE_W-1:0];
        end
    end

    // handshake: the parser moves when an input byte is held and the output register can take a word
    assign advance = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || advance;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_in_byte <= i_rx_byte;
        end
    end

    sld_parser #(
        .HEADER_LEN (HEADER_LEN),
        .IV_LEN     (IV_LEN)
    ) u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (advance),
        .i_byte       (r_in_byte),
        .i_sync_value (r_sync_value),
        .o_res        (res)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= res.emit;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && res.emit) begin
            r_out <= res;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_payload_byte  = r_out.payload_byte;
    assign o_frame_id      = r_out.frame_id;
    assign o_frame_length  = r_out.frame_length;
    assign o_padded_length = r_out.padded_length;
    assign o_byte_index    = r_out.byte_index;
    assign o_last_byte     = r_out.last_byte;

endmodule
